### rtl/core/rle_pkg.sv
// Shared types, register and mode codes, and the sine level function for the
// RGB LED effect generator. No dependencies.
`timescale 1ns / 1ps

package rle_pkg;

    localparam int PHASE_BITS_DEF     = 16;
    localparam int SINE_ADDR_BITS_DEF = 8;

    // mode codes
    localparam logic [2:0] MODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_RED     = 3'd1;
    localparam logic [2:0] MODE_GREEN   = 3'd2;
    localparam logic [2:0] MODE_BLUE    = 3'd3;
    localparam logic [2:0] MODE_BREATHE = 3'd4;
    localparam logic [2:0] MODE_STROBE  = 3'd5;
    localparam logic [2:0] MODE_RAINBOW = 3'd6;

    // register indexes (byte address 4*index)
    localparam int          REG_ADDR_BITS   = 5;
    localparam logic [2:0]  REG_MODE        = 3'd0;
    localparam logic [2:0]  REG_BREATHE_PER = 3'd1;
    localparam logic [2:0]  REG_STROBE_PER  = 3'd2;
    localparam logic [2:0]  REG_RAINBOW_PER = 3'd3;
    localparam logic [2:0]  REG_BREATHE_STP = 3'd4;
    localparam logic [2:0]  REG_RAINBOW_STP = 3'd5;

    localparam longint unsigned Q30_ONE    = 64'd1 << 30;
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] breathe_period;
        logic [15:0] strobe_period;
        logic [15:0] rainbow_period;
        logic [15:0] breathe_step;
        logic [15:0] rainbow_step;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic       emit;
        logic [2:0] mode;
        logic       strobe_red;
    } t_s1_ctl;

    // Level for quarter-wave offset t; lower selects the lower (negative) half-turn.
    // Used only to build constant tables at elaboration.
    function automatic logic [7:0] sine_level(input longint unsigned t, input bit lower,
                                              input int addr_bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned f;
        longint unsigned s;
        longint unsigned v;
        longint unsigned l;
        x  = (t * TWO_PI_Q30) >> addr_bits;
        x2 = (x * x) >> 30;
        f  = Q30_ONE - x2 / 72;
        f  = Q30_ONE - ((x2 * f) >> 30) / 42;
        f  = Q30_ONE - ((x2 * f) >> 30) / 20;
        f  = Q30_ONE - ((x2 * f) >> 30) / 6;
        s  = (x * f) >> 30;
        if (s > Q30_ONE) s = Q30_ONE;
        v = lower ? (Q30_ONE - s) : (Q30_ONE + s);
        l = (v * 64'd255) >> 31;
        if (l > 64'd255) l = 64'd255;
        return l[7:0];
    endfunction

endpackage

### rtl/core/rgb_led_effect_generator.sv
// Top level of the RGB LED effect generator: register file, input stage, output stage.
// Depends on rle_pkg, rle_timer_ctrl and rle_color_out.
`timescale 1ns / 1ps

// Each input word carries a millisecond time stamp. The block accepts one word every
// clock cycle while the color stream is ready. The input stage register and the output
// register are the only stages; the output register holds a finished color until it
// is taken, stalling the input stage meanwhile. Off and solid modes answer every word.
// Breathing, strobe and rainbow answer only when the wrapping time since their last
// update is above the mode's period, and otherwise drop the word. Levels come from
// constant quarter-wave sine tables, three lookups in parallel for rainbow.
// Write the registers only while no words are in flight.
module rgb_led_effect_generator #(
    parameter int PHASE_BITS     = rle_pkg::PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = rle_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rle_pkg::REG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // time stamp stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,  // [31:0] now_ms
    // color stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [23:0]                       m_axis_tdata   // [7:0] red, [15:8] green,
                                                             // [23:16] blue
);
    import rle_pkg::*;

    t_cfg                  r_cfg;
    t_s1_ctl               w_ctl;
    logic [PHASE_BITS-1:0] w_phase;
    logic                  w_take;
    logic [2:0]            w_reg_idx;
    logic                  w_wr;
    logic [7:0]            w_red;
    logic [7:0]            w_green;
    logic [7:0]            w_blue;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[REG_ADDR_BITS-1:2];
    assign w_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= MODE_OFF;
            r_cfg.breathe_period <= 16'd20;
            r_cfg.strobe_period  <= 16'd150;
            r_cfg.rainbow_period <= 16'd30;
            r_cfg.breathe_step   <= 16'd522;
            r_cfg.rainbow_step   <= 16'd313;
        end else if (w_wr) begin
            case (w_reg_idx)
                REG_MODE:        r_cfg.mode           <= pwdata[2:0];
                REG_BREATHE_PER: r_cfg.breathe_period <= pwdata[15:0];
                REG_STROBE_PER:  r_cfg.strobe_period  <= pwdata[15:0];
                REG_RAINBOW_PER: r_cfg.rainbow_period <= pwdata[15:0];
                REG_BREATHE_STP: r_cfg.breathe_step   <= pwdata[15:0];
                REG_RAINBOW_STP: r_cfg.rainbow_step   <= pwdata[15:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_MODE:        prdata = {29'd0, r_cfg.mode};
            REG_BREATHE_PER: prdata = {16'd0, r_cfg.breathe_period};
            REG_STROBE_PER:  prdata = {16'd0, r_cfg.strobe_period};
            REG_RAINBOW_PER: prdata = {16'd0, r_cfg.rainbow_period};
            REG_BREATHE_STP: prdata = {16'd0, r_cfg.breathe_step};
            REG_RAINBOW_STP: prdata = {16'd0, r_cfg.rainbow_step};
            default:         prdata = '0;
        endcase
    end

    rle_timer_ctrl #(.PHASE_BITS(PHASE_BITS)) u_timer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_now_ms   (s_axis_tdata),
        .i_take     (w_take),
        .o_ctl      (w_ctl),
        .o_phase    (w_phase)
    );

    rle_color_out #(.PHASE_BITS(PHASE_BITS), .SINE_ADDR_BITS(SINE_ADDR_BITS)) u_color (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_phase     (w_phase),
        .o_take      (w_take),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_red       (w_red),
        .o_green     (w_green),
        .o_blue      (w_blue)
    );

    assign m_axis_tdata = {w_blue, w_green, w_red};

endmodule

### rtl/core/rle_sine_rom.sv
// Quarter-wave sine level lookup: phase in, 8-bit drive level out.
// Depends on rle_pkg for the table-building function.
`timescale 1ns / 1ps

module rle_sine_rom #(
    parameter int PHASE_BITS     = rle_pkg::PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = rle_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic [PHASE_BITS-1:0] i_phase,
    output logic [7:0]            o_level
);
    import rle_pkg::*;

    localparam int S       = SINE_ADDR_BITS;
    localparam int QUARTER = 1 << (S - 2);
    localparam int DEPTH   = QUARTER + 1;

    logic [S-1:0] w_addr;
    logic [1:0]   w_quad;
    logic [S-3:0] w_ofs;
    logic [S-2:0] w_t;
    logic [7:0]   w_up [DEPTH];
    logic [7:0]   w_dn [DEPTH];

    // top address bits of the phase, padded below when the phase is narrow
    if (PHASE_BITS >= S) begin : g_addr_sel
        assign w_addr = i_phase[PHASE_BITS-1 -: S];
    end else begin : g_addr_pad
        assign w_addr = {i_phase, {(S - PHASE_BITS){1'b0}}};
    end

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_lut
        localparam logic [7:0] UP_LEVEL = sine_level(longint'(gi), 1'b0, S);
        localparam logic [7:0] DN_LEVEL = sine_level(longint'(gi), 1'b1, S);
        assign w_up[gi] = UP_LEVEL;
        assign w_dn[gi] = DN_LEVEL;
    end

    assign w_quad = w_addr[S-1:S-2];
    assign w_ofs  = w_addr[S-3:0];
    // mirror the offset in the second and fourth quadrants
    assign w_t    = w_quad[0] ? ((S-1)'(QUARTER) - {1'b0, w_ofs}) : {1'b0, w_ofs};
    assign o_level = w_quad[1] ? w_dn[w_t] : w_up[w_t];

endmodule

### rtl/core/rle_timer_ctrl.sv
// Input stage: elapsed-time check, phase and strobe state, input word register.
// Depends on rle_pkg for the configuration and control structs.
`timescale 1ns / 1ps

module rle_timer_ctrl #(
    parameter int PHASE_BITS = rle_pkg::PHASE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rle_pkg::t_cfg         i_cfg,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [31:0]           i_now_ms,
    input  logic                  i_take,
    output rle_pkg::t_s1_ctl      o_ctl,
    output logic [PHASE_BITS-1:0] o_phase
);
    import rle_pkg::*;

    logic [31:0]           r_last;
    logic [PHASE_BITS-1:0] r_phase;
    logic                  r_strobe;
    t_s1_ctl               r_ctl;

    logic [31:0]           w_elapsed;
    logic [15:0]           w_period;
    logic                  w_timed;
    logic                  w_fire;
    logic                  w_static;
    logic                  w_accept;
    logic [PHASE_BITS-1:0] n_phase;
    logic                  n_strobe;

    assign w_elapsed = i_now_ms - r_last;

    always_comb begin
        w_period = '0;
        w_timed  = 1'b0;
        w_static = 1'b0;
        case (i_cfg.mode)
            MODE_OFF, MODE_RED, MODE_GREEN, MODE_BLUE: begin
                w_static = 1'b1;
            end
            MODE_BREATHE: begin
                w_period = i_cfg.breathe_period;
                w_timed  = 1'b1;
            end
            MODE_STROBE: begin
                w_period = i_cfg.strobe_period;
                w_timed  = 1'b1;
            end
            MODE_RAINBOW: begin
                w_period = i_cfg.rainbow_period;
                w_timed  = 1'b1;
            end
            default: begin
                w_period = '0;
            end
        endcase
    end

    assign w_fire     = w_timed && (w_elapsed > {16'd0, w_period});
    assign o_in_ready = !r_ctl.valid || i_take;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_phase  = r_phase;
        n_strobe = r_strobe;
        if (i_cfg.mode == MODE_BREATHE) begin
            n_phase = r_phase + PHASE_BITS'(i_cfg.breathe_step);
        end else if (i_cfg.mode == MODE_RAINBOW) begin
            n_phase = r_phase + PHASE_BITS'(i_cfg.rainbow_step);
        end else if (i_cfg.mode == MODE_STROBE) begin
            n_strobe = !r_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= '0;
            r_phase  <= '0;
            r_strobe <= 1'b0;
            r_ctl    <= '0;
        end else begin
            if (w_accept && w_fire) begin
                r_last   <= i_now_ms;
                r_phase  <= n_phase;
                r_strobe <= n_strobe;
            end
            if (w_accept) begin
                r_ctl.valid      <= 1'b1;
                r_ctl.emit       <= w_static || w_fire;
                r_ctl.mode       <= i_cfg.mode;
                r_ctl.strobe_red <= n_strobe;
            end else if (i_take) begin
                r_ctl.valid <= 1'b0;
            end
        end
    end

    // phase state only moves on an accept, which the output stage sees at the same edge
    assign o_ctl   = r_ctl;
    assign o_phase = r_phase;

endmodule

### rtl/core/rle_color_out.sv
// Output stage: sine lookups for the three channels and the result word register.
// Depends on rle_pkg and rle_sine_rom.
`timescale 1ns / 1ps

module rle_color_out #(
    parameter int PHASE_BITS     = rle_pkg::PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = rle_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rle_pkg::t_s1_ctl      i_ctl,
    input  logic [PHASE_BITS-1:0] i_phase,
    output logic                  o_take,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue
);
    import rle_pkg::*;

    localparam longint unsigned TURN = longint'(1) << PHASE_BITS;
    localparam logic [PHASE_BITS-1:0] THIRD      = PHASE_BITS'((TURN + 1) / 3);
    localparam logic [PHASE_BITS-1:0] TWO_THIRDS = PHASE_BITS'((2 * TURN + 1) / 3);

    logic                  r_valid;
    logic [7:0]            r_red;
    logic [7:0]            r_green;
    logic [7:0]            r_blue;
    logic [PHASE_BITS-1:0] w_ph1;
    logic [PHASE_BITS-1:0] w_ph2;
    logic [7:0]            w_lvl0;
    logic [7:0]            w_lvl1;
    logic [7:0]            w_lvl2;
    logic [7:0]            n_red;
    logic [7:0]            n_green;
    logic [7:0]            n_blue;

    assign w_ph1 = i_phase + THIRD;
    assign w_ph2 = i_phase + TWO_THIRDS;

    rle_sine_rom #(.PHASE_BITS(PHASE_BITS), .SINE_ADDR_BITS(SINE_ADDR_BITS)) u_rom0 (
        .i_phase (i_phase),
        .o_level (w_lvl0)
    );
    rle_sine_rom #(.PHASE_BITS(PHASE_BITS), .SINE_ADDR_BITS(SINE_ADDR_BITS)) u_rom1 (
        .i_phase (w_ph1),
        .o_level (w_lvl1)
    );
    rle_sine_rom #(.PHASE_BITS(PHASE_BITS), .SINE_ADDR_BITS(SINE_ADDR_BITS)) u_rom2 (
        .i_phase (w_ph2),
        .o_level (w_lvl2)
    );

    always_comb begin
        n_red   = '0;
        n_green = '0;
        n_blue  = '0;
        case (i_ctl.mode)
            MODE_RED:     n_red   = 8'hFF;
            MODE_GREEN:   n_green = 8'hFF;
            MODE_BLUE:    n_blue  = 8'hFF;
            MODE_BREATHE: n_green = w_lvl0;
            MODE_STROBE: begin
                if (i_ctl.strobe_red) begin
                    n_red = 8'hFF;
                end else begin
                    n_blue = 8'hFF;
                end
            end
            MODE_RAINBOW: begin
                n_red   = w_lvl0;
                n_green = w_lvl1;
                n_blue  = w_lvl2;
            end
            default: begin
                n_red = '0;
            end
        endcase
    end

    assign o_take = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            // drop words that carry no result
            r_valid <= i_ctl.valid && i_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_ctl.valid) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_out_valid = r_valid;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;

endmodule
